// ===== rtl/swr_pkg.sv =====
// Shared types and constants for the square window rotator.
// Holds the request and result payload structs and the operation codes.
// No dependencies.
`default_nettype none

package swr_pkg;

  localparam int MAX_SIDE_DEF  = 32;
  localparam int CELL_BITS_DEF = 16;

  // Width of the size register; also wide enough for any coordinate in use.
  localparam int SIZE_W = 6;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [1:0] OP_NUMBER = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [3:0]  radius;
    logic        anticlockwise;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        status;
  } out_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/square_window_rotator.sv =====
// Top level of the square window rotator: size register, output register, sequencer.
// Depends on swr_pkg and swr_seq.
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_stall    swr_pkg::in_t
//   out_     result     out_valid / out_stall  swr_pkg::out_t
//   cfg_     write      cfg_we                 cfg_wdata (size)
//
// After reset the cell store is cleared one entry per cycle, all MAX_SIDE*MAX_SIDE
// entries, with in_stall high; size writes are taken throughout.
// From acceptance to a result in the output register: write and failed requests go
// straight to a result, read does one cell-store read, numbering writes the n*n cells,
// rotate copies the s*s window (s = window side) to scratch and writes it back. A result
// may wait in the output register while the next request is already being worked on.
`default_nettype none

module square_window_rotator #(
  parameter int MAX_SIDE  = swr_pkg::MAX_SIDE_DEF,
  parameter int CELL_BITS = swr_pkg::CELL_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire swr_pkg::in_t               in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output swr_pkg::out_t                   out_item,
  input  wire logic                       cfg_we,
  input  wire logic [swr_pkg::SIZE_W-1:0] cfg_wdata
);

  logic [swr_pkg::SIZE_W-1:0] size_r;
  logic                       out_valid_r;
  swr_pkg::out_t              out_item_r;
  swr_pkg::res_t              res;
  logic                       idle, res_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= swr_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
      out_item_r  <= res.data;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  swr_seq #(.MAX_SIDE(MAX_SIDE), .CELL_BITS(CELL_BITS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .idle     (idle),
    .size     (size_r),
    .res      (res),
    .res_take (res_take)
  );

  assign in_stall  = !idle;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/swr_ram.sv =====
// Synchronous memory with one write port and one registered read port.
// Used for both the cell store and the scratch store; no dependencies.
`default_nettype none

module swr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/swr_seq.sv =====
// Operation sequencer: address generation, window copy and write-back passes.
// Owns the cell and scratch memories (swr_ram); uses types from swr_pkg.
`default_nettype none

module swr_seq #(
  parameter int MAX_SIDE  = swr_pkg::MAX_SIDE_DEF,
  parameter int CELL_BITS = swr_pkg::CELL_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire swr_pkg::in_t              in_item,
  output logic                           idle,
  input  wire logic [swr_pkg::SIZE_W-1:0] size,
  output swr_pkg::res_t                  res,
  input  wire logic                      res_take
);

  localparam int SW    = swr_pkg::SIZE_W;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_NUMBER, ST_COPY, ST_BACK, ST_READ, ST_DONE
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] r, input logic [SW-1:0] c);
    return AW'(int'(r) * MAX_SIDE + int'(c));
  endfunction

  state_t               state_r;
  swr_pkg::in_t         item_r;
  logic [AW-1:0]        clr_r;
  logic [SW-1:0]        i_r, j_r, last_r, r0_r, c0_r;
  logic [CELL_BITS-1:0] cur_r;
  logic                 pw_valid_r, pw_scr_r;
  logic [AW-1:0]        pw_addr_r;
  logic                 fwd_r;
  logic [CELL_BITS-1:0] fwd_data_r;
  logic [15:0]          res_value_r;
  logic                 res_status_r;

  logic [SW-1:0] n_eff, row_ext, col_ext, rad_ext;
  logic [SW-1:0] i_step, j_step, win_r, win_c, sd_r, sd_c;
  logic          cell_ok, win_ok, last_elem, fwd_hit;

  logic                 cells_we, scr_we;
  logic [AW-1:0]        cells_waddr, cells_raddr, scr_waddr, scr_raddr;
  logic [CELL_BITS-1:0] cells_wdata, cells_rdata, scr_wdata, scr_rdata, back_data;

  assign n_eff   = (int'(size) > MAX_SIDE) ? SW'(MAX_SIDE) : size;
  assign row_ext = SW'(item_r.row);
  assign col_ext = SW'(item_r.col);
  assign rad_ext = SW'(item_r.radius);

  assign cell_ok = (row_ext < n_eff) && (col_ext < n_eff);
  assign win_ok  = (row_ext >= rad_ext) && (col_ext >= rad_ext) &&
                   ((row_ext + rad_ext) < n_eff) && ((col_ext + rad_ext) < n_eff);

  assign last_elem = (i_r == last_r) && (j_r == last_r);
  assign i_step    = (j_r == last_r) ? i_r + SW'(1) : i_r;
  assign j_step    = (j_r == last_r) ? '0 : j_r + SW'(1);

  assign win_r = r0_r + i_r;
  assign win_c = c0_r + j_r;
  // Destination of window element (i, j) inside the scratch square.
  assign sd_r  = item_r.anticlockwise ? last_r - j_r : j_r;
  assign sd_c  = item_r.anticlockwise ? i_r : last_r - i_r;

  assign cells_raddr = (state_r == ST_COPY) ? addr_of(win_r, win_c) : addr_of(row_ext, col_ext);
  assign scr_raddr   = addr_of(i_r, j_r);

  assign scr_we    = pw_valid_r && pw_scr_r;
  assign scr_waddr = pw_addr_r;
  assign scr_wdata = cells_rdata;

  // The first write-back read can hit the scratch entry written in the same cycle.
  assign fwd_hit   = (state_r == ST_BACK) && scr_we && (pw_addr_r == scr_raddr);
  assign back_data = fwd_r ? fwd_data_r : scr_rdata;

  always_comb begin
    cells_we    = 1'b0;
    cells_waddr = pw_addr_r;
    cells_wdata = back_data;
    if (state_r == ST_CLEAR) begin
      cells_we    = 1'b1;
      cells_waddr = clr_r;
      cells_wdata = '0;
    end else if (state_r == ST_NUMBER) begin
      cells_we    = 1'b1;
      cells_waddr = addr_of(i_r, j_r);
      cells_wdata = cur_r;
    end else if (state_r == ST_DISPATCH && item_r.op == swr_pkg::OP_WRITE && cell_ok) begin
      cells_we    = 1'b1;
      cells_waddr = addr_of(row_ext, col_ext);
      cells_wdata = CELL_BITS'(item_r.value);
    end else if (pw_valid_r && !pw_scr_r) begin
      cells_we    = 1'b1;
    end
  end

  swr_ram #(.DEPTH(DEPTH), .WIDTH(CELL_BITS)) u_cells (
    .clk   (clk),
    .we    (cells_we),
    .waddr (cells_waddr),
    .wdata (cells_wdata),
    .raddr (cells_raddr),
    .rdata (cells_rdata)
  );

  swr_ram #(.DEPTH(DEPTH), .WIDTH(CELL_BITS)) u_scratch (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      pw_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      pw_valid_r <= 1'b0;
      fwd_r      <= fwd_hit;
      fwd_data_r <= cells_rdata;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            state_r <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          res_value_r  <= '0;
          res_status_r <= 1'b0;
          i_r          <= '0;
          j_r          <= '0;
          unique case (item_r.op)
            swr_pkg::OP_NUMBER: begin
              if (n_eff == '0) begin
                state_r <= ST_DONE;
              end else begin
                last_r  <= n_eff - SW'(1);
                cur_r   <= CELL_BITS'(1);
                state_r <= ST_NUMBER;
              end
            end
            swr_pkg::OP_WRITE: begin
              res_status_r <= !cell_ok;
              state_r      <= ST_DONE;
            end
            swr_pkg::OP_ROTATE: begin
              if (win_ok) begin
                last_r  <= rad_ext + rad_ext;
                r0_r    <= row_ext - rad_ext;
                c0_r    <= col_ext - rad_ext;
                state_r <= ST_COPY;
              end else begin
                res_status_r <= 1'b1;
                state_r      <= ST_DONE;
              end
            end
            swr_pkg::OP_READ: begin
              if (cell_ok) begin
                state_r <= ST_READ;
              end else begin
                res_status_r <= 1'b1;
                state_r      <= ST_DONE;
              end
            end
            default: state_r <= ST_DONE;
          endcase
        end
        ST_NUMBER: begin
          cur_r <= cur_r + CELL_BITS'(1);
          i_r   <= i_step;
          j_r   <= j_step;
          if (last_elem) begin
            state_r <= ST_DONE;
          end
        end
        ST_COPY: begin
          pw_valid_r <= 1'b1;
          pw_scr_r   <= 1'b1;
          pw_addr_r  <= addr_of(sd_r, sd_c);
          i_r        <= i_step;
          j_r        <= j_step;
          if (last_elem) begin
            i_r     <= '0;
            j_r     <= '0;
            state_r <= ST_BACK;
          end
        end
        ST_BACK: begin
          pw_valid_r <= 1'b1;
          pw_scr_r   <= 1'b0;
          pw_addr_r  <= addr_of(win_r, win_c);
          i_r        <= i_step;
          j_r        <= j_step;
          if (last_elem) begin
            state_r <= ST_DONE;
          end
        end
        ST_READ: begin
          res_value_r <= 16'(cells_rdata);
          state_r     <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign idle       = (state_r == ST_IDLE);
  assign res.valid  = (state_r == ST_DONE);
  assign res.data   = '{read_value: res_value_r, status: res_status_r};

  // The last write-back lands while the result waits, never after a new request.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pw_valid_r)
    else $error("pending write still open in idle");

  a_fwd_scope: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (state_r == ST_BACK || state_r == ST_DONE))
    else $error("scratch forward outside write-back");

  a_counter_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY || state_r == ST_BACK) |-> (i_r <= last_r && j_r <= last_r))
    else $error("window counter beyond window");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire
